// ===== src/bbf_pkg.sv =====
// Package for the bounded byte FIFO: payload structs, command codes,
// back-end states, register map and sizing constants.
// No dependencies.
package bbf_pkg;

    localparam int BBF_DEPTH   = 64;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = 1;
    localparam int ADDR_W      = 3;
    localparam int MAX_FILL    = 64;
    localparam logic [6:0] CAP_RESET = 7'd64;

    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_POP   = 2'd1,
        CMD_PEEK  = 2'd2,
        CMD_END   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PEEK_RD,
        BK_PEEK_OUT
    } bk_state_t;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] data_byte;
        logic [6:0] length;
    } req_t;

    typedef struct packed {
        logic        accepted;
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        last;
        logic [6:0]  fill_level;
        logic [6:0]  space_left;
        logic [63:0] total_written;
        logic [63:0] total_read;
        logic        ended;
        logic        at_eof;
    } res_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [7:0] data_byte;
        logic [6:0] length;
    } q_item_t;

endpackage

// ===== src/bbf_front.sv =====
// Front end: accepts input items, decodes the command and queues them
// in a two-entry command queue for the back end. Depends on bbf_pkg.
module bbf_front import bbf_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  req_t    s_data,
    output logic    q_valid,
    output q_item_t q_item,
    input  logic    q_pop
);

    q_item_t             slot_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     count_reg, count_next;
    q_item_t             item_in;
    logic                push;
    logic                pop;

    always_comb begin
        item_in.data_byte = s_data.data_byte;
        item_in.length    = s_data.length;
        item_in.cmd       = cmd_t'(s_data.command);
    end

    assign s_ready = (count_reg != (QPTR_W+1)'(QDEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_pop && q_valid;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

// ===== src/bbf_back.sv =====
// Back end: byte store, fill and count state, command sequencer and the
// result output register. Depends on bbf_pkg.
module bbf_back import bbf_pkg::*; #(
    parameter int DEPTH = BBF_DEPTH
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [6:0] capacity,
    input  logic       q_valid,
    input  q_item_t    q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  logic       m_ready,
    output res_t       m_data
);

    localparam int AW    = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [7:0]       mem [DEPTH];
    logic [7:0]       rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    wr_addr;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;

    bk_state_t        state_reg, state_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CNT_W-1:0] held_reg, held_next;
    logic             done_reg, done_next;
    logic [63:0]      wr_cnt_reg, wr_cnt_next;
    logic [63:0]      rd_cnt_reg, rd_cnt_next;
    logic [6:0]       idx_reg, idx_next;
    logic [6:0]       peek_n_reg, peek_n_next;
    logic             m_valid_reg, m_valid_next;
    res_t             res_reg, res_next;

    logic             out_free;
    logic [6:0]       cap_eff;
    logic [6:0]       held_ext;
    logic [6:0]       n;
    logic             peek_last;

    function automatic logic [AW-1:0] wrap(input logic [AW:0] sum);
        logic [AW:0] s;
        s = sum;
        if (s >= (AW+1)'(DEPTH)) begin
            s = s - (AW+1)'(DEPTH);
        end
        return s[AW-1:0];
    endfunction

    function automatic res_t mk_res(
        input logic        acc,
        input logic [7:0]  b,
        input logic        bv,
        input logic        lst,
        input logic [6:0]  fill,
        input logic [6:0]  cap,
        input logic [63:0] wc,
        input logic [63:0] rc,
        input logic        dn
    );
        res_t r;
        r.accepted      = acc;
        r.out_byte      = b;
        r.byte_valid    = bv;
        r.last          = lst;
        r.fill_level    = fill;
        r.space_left    = (cap > fill) ? cap - fill : 7'd0;
        r.total_written = wc;
        r.total_read    = rc;
        r.ended         = dn;
        r.at_eof        = (fill == 7'd0) && dn;
        return r;
    endfunction

    assign out_free  = !m_valid_reg || m_ready;
    assign cap_eff   = (capacity > 7'(DEPTH)) ? 7'(DEPTH) : capacity;
    assign held_ext  = 7'(held_reg);
    assign n         = (q_item.length < held_ext) ? q_item.length : held_ext;
    assign peek_last = (idx_reg + 7'd1 == peek_n_reg);
    assign wr_addr   = wrap({1'b0, head_reg} + (AW+1)'(held_reg));
    assign rd_addr   = wrap({1'b0, head_reg} + (AW+1)'(idx_reg));
    assign m_valid   = m_valid_reg;
    assign m_data    = res_reg;

    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        held_next    = held_reg;
        done_next    = done_reg;
        wr_cnt_next  = wr_cnt_reg;
        rd_cnt_next  = rd_cnt_reg;
        idx_next     = idx_reg;
        peek_n_next  = peek_n_reg;
        m_valid_next = m_valid_reg && !m_ready;
        res_next     = res_reg;
        q_pop        = 1'b0;
        mem_we       = 1'b0;
        rd_en        = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid && out_free) begin
                    q_pop        = 1'b1;
                    m_valid_next = 1'b1;
                    unique case (q_item.cmd)
                        CMD_WRITE: begin
                            if (!done_reg && held_ext < cap_eff) begin
                                mem_we      = 1'b1;
                                held_next   = held_reg + 1'b1;
                                wr_cnt_next = wr_cnt_reg + 64'd1;
                            end
                            res_next = mk_res(mem_we, 8'd0, 1'b0, 1'b1, 7'(held_next),
                                              cap_eff, wr_cnt_next, rd_cnt_reg, done_reg);
                        end
                        CMD_POP: begin
                            head_next   = wrap({1'b0, head_reg} + (AW+1)'(n));
                            held_next   = held_reg - CNT_W'(n);
                            rd_cnt_next = rd_cnt_reg + 64'(n);
                            res_next = mk_res(1'b0, 8'd0, 1'b0, 1'b1, 7'(held_next),
                                              cap_eff, wr_cnt_reg, rd_cnt_next, done_reg);
                        end
                        CMD_PEEK: begin
                            res_next = mk_res(1'b0, 8'd0, 1'b0, 1'b1, held_ext,
                                              cap_eff, wr_cnt_reg, rd_cnt_reg, done_reg);
                            if (n != 7'd0) begin
                                m_valid_next = m_valid_reg && !m_ready;
                                res_next     = res_reg;
                                peek_n_next  = n;
                                idx_next     = 7'd0;
                                state_next   = BK_PEEK_RD;
                            end
                        end
                        default: begin
                            done_next = 1'b1;
                            res_next = mk_res(1'b0, 8'd0, 1'b0, 1'b1, held_ext,
                                              cap_eff, wr_cnt_reg, rd_cnt_reg, 1'b1);
                        end
                    endcase
                end
            end
            BK_PEEK_RD: begin
                rd_en      = 1'b1;
                state_next = BK_PEEK_OUT;
            end
            BK_PEEK_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    res_next = mk_res(1'b0, rd_data_reg, 1'b1, peek_last, held_ext,
                                      cap_eff, wr_cnt_reg, rd_cnt_reg, done_reg);
                    idx_next   = idx_reg + 7'd1;
                    state_next = peek_last ? BK_IDLE : BK_PEEK_RD;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            head_reg    <= '0;
            held_reg    <= '0;
            done_reg    <= 1'b0;
            wr_cnt_reg  <= '0;
            rd_cnt_reg  <= '0;
            idx_reg     <= '0;
            peek_n_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            held_reg    <= held_next;
            done_reg    <= done_next;
            wr_cnt_reg  <= wr_cnt_next;
            rd_cnt_reg  <= rd_cnt_next;
            idx_reg     <= idx_next;
            peek_n_reg  <= peek_n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg <= res_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= q_item.data_byte;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

// ===== src/bounded_byte_fifo_with_eof_top.sv =====
//  channel   ports              direction  payload
//  input     s_valid/s_ready    in         req_t  s_data
//  result    m_valid/m_ready    out        res_t  m_data
//  config    APB (psel..pready) in/out     capacity at byte address 0
//
//  Write, pop, end-input and an empty peek take one cycle in the back end
//  once the result register is free; a peek of n bytes takes one dispatch
//  cycle plus two per byte, set by the registered read port of the store.
//  A two-entry command queue keeps taking items while results stall.
//  aresetn is synchronous, active low; the byte store is not cleared.
// Top level: configuration register, front end and back end.
// Depends on bbf_pkg, bbf_front and bbf_back.
module bounded_byte_fifo_with_eof_top import bbf_pkg::*; #(
    parameter int DEPTH = BBF_DEPTH
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  req_t              s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output res_t              m_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [6:0] cap_reg;
    logic       q_valid;
    q_item_t    q_item;
    logic       q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_CAPACITY) ? {25'd0, cap_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && paddr[2] == REG_CAPACITY) begin
            cap_reg <= pwdata[6:0];
        end
    end

    bbf_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    bbf_back #(
        .DEPTH (DEPTH)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .capacity (cap_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== src/bbf_chk.sv =====
// Port-level checker for the bounded byte FIFO, bound to the top level.
// Depends on bbf_pkg.
module bbf_chk import bbf_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input res_t m_data,
    input logic pready
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.at_eof == (m_data.fill_level == 7'd0 && m_data.ended))
        else $error("eof flag inconsistent");

    a_level: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (8'(m_data.fill_level) + 8'(m_data.space_left)) <= 8'(MAX_FILL))
        else $error("fill plus space exceeds depth");

    a_acc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.accepted |-> m_data.last && !m_data.byte_valid
                                       && m_data.fill_level != 7'd0)
        else $error("accepted write result malformed");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("config port not ready");

endmodule

bind bounded_byte_fifo_with_eof_top bbf_chk u_chk (.*);

// ===== tb/bounded_byte_fifo_with_eof_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for bounded_byte_fifo_with_eof_top: a scoreboard class predicts
// every result item from the accepted commands and checks them in order.
// Depends on bbf_pkg and the top level of the block.
module bounded_byte_fifo_with_eof_top_tb;
    import bbf_pkg::*;

    localparam logic [ADDR_W-1:0] CAP_ADDR     = 3'd0;
    localparam logic [ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;

    class fifo_scoreboard;
        logic [7:0]  byte_mem [BBF_DEPTH];
        logic [5:0]  head;
        logic [6:0]  held;
        logic        done;
        logic [63:0] wr_cnt;
        logic [63:0] rd_cnt;
        logic [6:0]  cap;
        res_t        due_results [$];
        int          errors;
        int          result_no;

        function new();
            head = '0;
            held = '0;
            done = 1'b0;
            wr_cnt = '0;
            rd_cnt = '0;
            cap = CAP_RESET;
            errors = 0;
            result_no = 0;
        endfunction

        function void set_capacity(logic [6:0] value);
            cap = value;
        endfunction

        function logic [6:0] eff_cap();
            return (cap > BBF_DEPTH) ? 7'(BBF_DEPTH) : cap;
        endfunction

        function void add_due(res_t r);
            due_results.insert(due_results.size(), r);
        endfunction

        function res_t take_due();
            res_t r;
            r = due_results[0];
            due_results.delete(0);
            return r;
        endfunction

        function res_t make_result(logic acc, logic [7:0] b, logic bv, logic lst);
            res_t r;
            logic [6:0] ec;
            ec = eff_cap();
            r.accepted      = acc;
            r.out_byte      = b;
            r.byte_valid    = bv;
            r.last          = lst;
            r.fill_level    = held;
            r.space_left    = (ec > held) ? ec - held : 7'd0;
            r.total_written = wr_cnt;
            r.total_read    = rd_cnt;
            r.ended         = done;
            r.at_eof        = (held == 0) && done;
            return r;
        endfunction

        function void note_item(req_t req);
            logic [6:0] n;
            logic       acc;
            n = (req.length < held) ? req.length : held;
            case (cmd_t'(req.command))
                CMD_WRITE: begin
                    acc = 1'b0;
                    if (!done && held < eff_cap()) begin
                        byte_mem[6'(head + held)] = req.data_byte;
                        held++;
                        wr_cnt++;
                        acc = 1'b1;
                    end
                    add_due(make_result(acc, 8'd0, 1'b0, 1'b1));
                end
                CMD_POP: begin
                    head = 6'(head + n);
                    held = held - n;
                    rd_cnt = rd_cnt + n;
                    add_due(make_result(1'b0, 8'd0, 1'b0, 1'b1));
                end
                CMD_PEEK: begin
                    if (n == 0) begin
                        add_due(make_result(1'b0, 8'd0, 1'b0, 1'b1));
                    end else begin
                        for (int i = 0; i < n; i++) begin
                            add_due(make_result(1'b0, byte_mem[6'(head + i)],
                                                1'b1, i == n - 1));
                        end
                    end
                end
                default: begin
                    done = 1'b1;
                    add_due(make_result(1'b0, 8'd0, 1'b0, 1'b1));
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("ERROR: result %0d %s: got 'h%0h, expected 'h%0h",
                     result_no, what, got, want);
            errors++;
        endtask

        task cmp(string what, logic [63:0] got, logic [63:0] want);
            if (got !== want) report(what, got, want);
        endtask

        task check_result(res_t got);
            res_t want;
            if (due_results.size() == 0) begin
                report("arrived with nothing outstanding", 64'(got), 64'd0);
                result_no++;
                return;
            end
            want = take_due();
            cmp("accepted", 64'(got.accepted), 64'(want.accepted));
            cmp("out_byte", 64'(got.out_byte), 64'(want.out_byte));
            cmp("byte_valid", 64'(got.byte_valid), 64'(want.byte_valid));
            cmp("last", 64'(got.last), 64'(want.last));
            cmp("fill_level", 64'(got.fill_level), 64'(want.fill_level));
            cmp("space_left", 64'(got.space_left), 64'(want.space_left));
            cmp("total_written", got.total_written, want.total_written);
            cmp("total_read", got.total_read, want.total_read);
            cmp("ended", 64'(got.ended), 64'(want.ended));
            cmp("at_eof", 64'(got.at_eof), 64'(want.at_eof));
            result_no++;
        endtask
    endclass

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    req_t              s_data;
    logic              m_valid;
    logic              m_ready;
    res_t              m_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    fifo_scoreboard sb;
    bit             idle_on;
    int             long_hold;
    int             rx_gap = 0;
    int             phase_cap [7] = '{127, 64, 1, 2, 33, 0, 64};

    bounded_byte_fifo_with_eof_top i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    // result side: check each accepted item, then choose ready for the next cycle
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) sb.check_result(m_data);
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (rx_gap > 0) begin
                rx_gap--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rx_gap = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    function req_t pack_req(cmd_t c, logic [7:0] d, logic [6:0] len);
        req_t r;
        r.command   = c;
        r.data_byte = d;
        r.length    = len;
        return r;
    endfunction

    function req_t rand_req(int write_pct);
        int   k;
        int   j;
        cmd_t c;
        logic [6:0] len;
        k = $urandom_range(0, 99);
        if (k < write_pct) c = CMD_WRITE;
        else if (k < write_pct + (100 - write_pct) / 2) c = CMD_PEEK;
        else c = CMD_POP;
        j = $urandom_range(0, 9);
        if (j < 7) len = 7'($urandom_range(0, 4));
        else if (j < 9) len = 7'($urandom_range(5, 64));
        else len = 7'($urandom_range(65, 127));
        return pack_req(c, 8'($urandom_range(0, 255)), len);
    endfunction

    task send_item(input req_t r);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            gap = $urandom_range(1, 10);
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= r;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_item(r);
    endtask

    task wait_drained();
        s_valid <= 1'b0;
        while (sb.due_results.size() > 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task cfg_write(input logic [ADDR_W-1:0] addr, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == CAP_ADDR) sb.set_capacity(value[6:0]);
    endtask

    initial begin
        int w;
        int cap;
        sb        = new();
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_data    = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        idle_on   = 1'b1;
        long_hold = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty peek and pop, byte extremes, clipped lengths
        send_item(pack_req(CMD_PEEK, 8'h3C, 7'd0));
        send_item(pack_req(CMD_POP, 8'h00, 7'd5));
        send_item(pack_req(CMD_WRITE, 8'h00, 7'd0));
        send_item(pack_req(CMD_WRITE, 8'hFF, 7'd127));
        send_item(pack_req(CMD_WRITE, 8'hA5, 7'd64));
        send_item(pack_req(CMD_PEEK, 8'hFF, 7'd127));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd2));
        send_item(pack_req(CMD_POP, 8'h5A, 7'd1));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd0));
        // capacity lowered below the fill level
        wait_drained();
        cfg_write(CAP_ADDR, 32'd1);
        send_item(pack_req(CMD_WRITE, 8'h11, 7'd0));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd64));
        send_item(pack_req(CMD_POP, 8'h00, 7'd64));
        send_item(pack_req(CMD_WRITE, 8'h22, 7'd0));
        send_item(pack_req(CMD_WRITE, 8'h33, 7'd0));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd1));
        // zero capacity, then a write to an unmapped register
        wait_drained();
        cfg_write(CAP_ADDR, 32'd0);
        send_item(pack_req(CMD_WRITE, 8'h44, 7'd0));
        send_item(pack_req(CMD_POP, 8'h00, 7'd0));
        wait_drained();
        cfg_write(UNMAPPED_ADDR, 32'd64);
        send_item(pack_req(CMD_WRITE, 8'h55, 7'd0));

        for (int p = 0; p < 7; p++) begin
            wait_drained();
            cap = (p == 5) ? $urandom_range(3, 63) : phase_cap[p];
            cfg_write(CAP_ADDR, 32'(cap));
            idle_on = (p != 6);
            if (p == 0) begin
                // fill past the saturated capacity, then peek the whole store
                repeat (66) send_item(pack_req(CMD_WRITE, 8'($urandom_range(0, 255)),
                                               7'($urandom_range(0, 127))));
                send_item(pack_req(CMD_PEEK, 8'($urandom_range(0, 255)), 7'd64));
            end
            for (int k = 0; k < 36; k++) begin
                if (p == 1 && k == 5) long_hold = 400;
                if (p == 3 && k == 18) wait_drained();
                send_item(rand_req((p == 1) ? 70 : 50));
            end
        end

        // end of input: refused writes, draining and eof
        send_item(pack_req(CMD_WRITE, 8'h66, 7'd0));
        send_item(pack_req(CMD_WRITE, 8'h77, 7'd0));
        send_item(pack_req(CMD_END, 8'hC3, 7'd9));
        send_item(pack_req(CMD_WRITE, 8'h88, 7'd0));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd3));
        send_item(pack_req(CMD_POP, 8'h00, 7'd127));
        send_item(pack_req(CMD_PEEK, 8'h00, 7'd5));
        send_item(pack_req(CMD_WRITE, 8'h99, 7'd0));
        send_item(pack_req(CMD_END, 8'h00, 7'd0));
        send_item(pack_req(CMD_POP, 8'h00, 7'd0));

        s_valid <= 1'b0;
        w = 0;
        while (sb.due_results.size() > 0 && w < 20000) begin
            @(posedge aclk);
            w++;
        end
        if (sb.due_results.size() > 0) begin
            sb.report("still outstanding at the end", 64'(sb.due_results.size()), 64'd0);
        end
        repeat (20) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
